>>> hw/rtl/joystick_to_heading_drive_unit_macros.svh
// Assertion macros shared by the joystick drive unit RTL
`ifndef JOYSTICK_TO_HEADING_DRIVE_UNIT_MACROS_SVH
`define JOYSTICK_TO_HEADING_DRIVE_UNIT_MACROS_SVH

// Check a same-cycle implication on clk, off while rst_n is low
`define JHD_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check an implication in the next cycle on clk, off while rst_n is low
`define JHD_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/jhd_pkg.sv
// Shared types, constants and trig tables of the joystick drive unit
`timescale 1ns / 1ps

package jhd_pkg;

  // Action codes
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_MOVE   = 2'd1;
  localparam logic [1:0] ACT_ROTATE = 2'd2;

  // Configuration port and register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVELS   = 1'b1;
  localparam logic [7:0] DEADZONE_RST = 8'd2;
  localparam logic [3:0] LEVELS_RST   = 4'd5;
  localparam logic [3:0] LEVEL_MAX    = 4'd7;

  // Angles in degrees
  localparam logic [8:0] DEG_0   = 9'd0;
  localparam logic [8:0] DEG_90  = 9'd90;
  localparam logic [8:0] DEG_180 = 9'd180;
  localparam logic [8:0] DEG_270 = 9'd270;
  localparam logic [8:0] DEG_360 = 9'd360;
  localparam logic [8:0] DEG_450 = 9'd450;
  localparam logic [5:0] DEG_45  = 6'd45;
  localparam logic [8:0] MAG_FULL = 9'd256;

  // Iteration schedule: angle search on the first steps, square root on all
  localparam int ITER_STEPS   = 8;
  localparam int STEP_W       = 3;
  localparam int SEARCH_STEPS = 6;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ITER_STEPS - 1);

  // Sine and cosine of whole degrees, 40 fractional bits
  localparam int TRIG_FRAC    = 40;
  localparam int TRIG_W       = 40;
  localparam int TRIG_ENTRIES = 64;
  localparam int OCT_STEPS    = 44;
  localparam logic [TRIG_W:0] TRIG_ONE = {1'b1, {TRIG_W{1'b0}}};
  localparam logic [TRIG_W:0] SIN1     = 41'd19189123810;
  localparam logic [TRIG_W:0] COS1     = 41'd1099344166829;

  typedef logic [TRIG_ENTRIES-1:0][TRIG_W-1:0] trig_tab_t;

  // Build the table by rotating one degree at a time
  function automatic trig_tab_t trig_table(input logic want_cos);
    trig_tab_t tab;
    logic [2*TRIG_W+1:0] c_q;
    logic [2*TRIG_W+1:0] s_q;
    logic [2*TRIG_W+1:0] c_new;
    logic [2*TRIG_W+1:0] s_new;
    tab = '0;
    c_q = (2*TRIG_W+2)'(TRIG_ONE);
    s_q = '0;
    for (int i = 1; i <= OCT_STEPS; i++) begin
      c_new = (c_q * COS1 - s_q * SIN1) >> TRIG_FRAC;
      s_new = (s_q * COS1 + c_q * SIN1) >> TRIG_FRAC;
      c_q = c_new;
      s_q = s_new;
      tab[i[5:0]] = want_cos ? c_q[TRIG_W-1:0] : s_q[TRIG_W-1:0];
    end
    return tab;
  endfunction

  localparam trig_tab_t SIN_TAB = trig_table(1'b0);
  localparam trig_tab_t COS_TAB = trig_table(1'b1);

  // Absolute value of an 8-bit two's complement number
  function automatic logic [7:0] mag8(input logic signed [7:0] v);
    return v[7] ? 8'(~v + 8'd1) : 8'(v);
  endfunction

  typedef struct packed {
    logic signed [7:0] change_lx;
    logic signed [7:0] change_ly;
    logic signed [7:0] change_rx;
    logic signed [7:0] change_ry;
    logic signed [7:0] stick_lx;
    logic signed [7:0] stick_ly;
    logic signed [7:0] stick_rx;
    logic              triangle_released;
  } jhd_event_t;

  typedef struct packed {
    logic [1:0] action;
    logic [8:0] heading_deg;
    logic [8:0] magnitude;
    logic       spin_right;
    logic [2:0] player_level;
    logic       player_update;
  } jhd_result_t;

  typedef struct packed {
    logic              load;
    logic              prep;
    logic              step;
    logic [STEP_W-1:0] step_idx;
    logic              finish;
  } jhd_cmd_t;

  typedef struct packed {
    logic out_free;
  } jhd_stat_t;

endpackage

>>> hw/rtl/jhd_if.sv
// Valid/ready channel interfaces for gamepad events and drive commands
`timescale 1ns / 1ps

interface jhd_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] change_lx;
  logic signed [7:0] change_ly;
  logic signed [7:0] change_rx;
  logic signed [7:0] change_ry;
  logic signed [7:0] stick_lx;
  logic signed [7:0] stick_ly;
  logic signed [7:0] stick_rx;
  logic              triangle_released;

  modport source (output valid, change_lx, change_ly, change_rx, change_ry,
                  stick_lx, stick_ly, stick_rx, triangle_released, input ready);
  modport sink (input valid, change_lx, change_ly, change_rx, change_ry,
                stick_lx, stick_ly, stick_rx, triangle_released, output ready);
endinterface

interface jhd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [8:0] heading_deg;
  logic [8:0] magnitude;
  logic       spin_right;
  logic [2:0] player_level;
  logic       player_update;

  modport source (output valid, action, heading_deg, magnitude, spin_right,
                  player_level, player_update, input ready);
  modport sink (input valid, action, heading_deg, magnitude, spin_right,
                player_level, player_update, output ready);
endinterface

>>> hw/rtl/joystick_to_heading_drive_unit.sv
// Top level of the joystick drive unit: gamepad event in, drive command out
// Each accepted event yields one command: accept, fold the stick vector into
// an octant, eight shared iterations that find the whole-degree angle bit by
// bit on the first six (table compare of s*cos against l*sin) and the
// magnitude square root one bit per step, then form the result. The next
// event is taken once the result has moved into the output register, so no
// new event enters while one is in flight. The speed level advances when an
// event with a triangle release is accepted. Configuration writes take effect
// at once and must be made only while the unit is idle; the block does not check.
`timescale 1ns / 1ps

module joystick_to_heading_drive_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  jhd_in_if.sink                              in_item,
  jhd_out_if.source                           out_item,
  input  logic                                cfg_we,
  input  logic [jhd_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [jhd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  jhd_pkg::jhd_cmd_t    cmd;
  jhd_pkg::jhd_stat_t   stat;
  jhd_pkg::jhd_event_t  evt;
  jhd_pkg::jhd_result_t res;
  logic                 in_ready;
  logic                 out_valid;

  // Gather the event payload
  assign evt.change_lx         = in_item.change_lx;
  assign evt.change_ly         = in_item.change_ly;
  assign evt.change_rx         = in_item.change_rx;
  assign evt.change_ry         = in_item.change_ry;
  assign evt.stick_lx          = in_item.stick_lx;
  assign evt.stick_ly          = in_item.stick_ly;
  assign evt.stick_rx          = in_item.stick_rx;
  assign evt.triangle_released = in_item.triangle_released;
  assign in_item.ready         = in_ready;

  jhd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  jhd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .evt       (evt),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_item.ready),
    .res       (res)
  );

  // Present the command
  assign out_item.valid         = out_valid;
  assign out_item.action        = res.action;
  assign out_item.heading_deg   = res.heading_deg;
  assign out_item.magnitude     = res.magnitude;
  assign out_item.spin_right    = res.spin_right;
  assign out_item.player_level  = res.player_level;
  assign out_item.player_update = res.player_update;

endmodule

>>> hw/rtl/jhd_ctrl.sv
// Controller state machine sequencing one item through the datapath
`timescale 1ns / 1ps
`include "joystick_to_heading_drive_unit_macros.svh"

module jhd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output jhd_pkg::jhd_cmd_t  cmd,
  input  jhd_pkg::jhd_stat_t stat
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PREP   = 4'b0010,
    ST_ITER   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [jhd_pkg::STEP_W-1:0] step_r, step_nxt;

  // Next state and step count
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        step_nxt  = '0;
        state_nxt = ST_ITER;
      end
      ST_ITER: begin
        step_nxt = step_r + 1'b1;
        if (step_r == jhd_pkg::LAST_STEP) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Drive commands
  assign in_ready     = (state_r == ST_IDLE);
  assign cmd.load     = in_valid && in_ready;
  assign cmd.prep     = (state_r == ST_PREP);
  assign cmd.step     = (state_r == ST_ITER);
  assign cmd.step_idx = step_r;
  assign cmd.finish   = (state_r == ST_FINISH) && stat.out_free;

  `JHD_CHECK_NEXT(a_accept_to_prep, in_valid && in_ready, state_r == ST_PREP, "accepted item did not start")
  `JHD_CHECK_NEXT(a_iter_done, state_r == ST_ITER && step_r == jhd_pkg::LAST_STEP, state_r == ST_FINISH, "iterations did not end")

endmodule

>>> hw/rtl/jhd_dp.sv
// Datapath: activity test, level counter, angle search, square root, result register
`timescale 1ns / 1ps
`include "joystick_to_heading_drive_unit_macros.svh"

module jhd_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  jhd_pkg::jhd_cmd_t                   cmd,
  output jhd_pkg::jhd_stat_t                  stat,
  input  jhd_pkg::jhd_event_t                 evt,
  input  logic                                cfg_we,
  input  logic [jhd_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [jhd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output jhd_pkg::jhd_result_t                res
);

  // Configuration and speed level
  logic [7:0] dz_r;
  logic [3:0] lvl_cnt_r;
  logic [2:0] level_r;

  // Latched item
  logic signed [7:0] lx_r, ly_r, rx_r;
  logic              left_on_r, right_on_r;
  logic [2:0]        plevel_r;
  logic              pupd_r;

  // Angle search and root state
  logic [7:0]  s_r, l_r;
  logic [8:0]  base_r;
  logic        sub_r;
  logic [16:0] sq_r;
  logic [5:0]  k_r;
  logic [7:0]  root_r;

  // Result register
  logic                 out_valid_r;
  jhd_pkg::jhd_result_t res_r, res_nxt;

  // Activity and level advance, from the incoming item
  logic [8:0] l_sum, r_sum;
  logic       left_on, right_on;
  logic [3:0] lvl_inc;
  logic [2:0] lvl_nxt;

  assign l_sum = {1'b0, jhd_pkg::mag8(evt.change_lx)} + {1'b0, jhd_pkg::mag8(evt.change_ly)};
  assign r_sum = {1'b0, jhd_pkg::mag8(evt.change_rx)} + {1'b0, jhd_pkg::mag8(evt.change_ry)};
  assign left_on  = l_sum > {1'b0, dz_r};
  assign right_on = r_sum > {1'b0, dz_r};
  assign lvl_inc  = {1'b0, level_r} + 4'd1;
  assign lvl_nxt  = (lvl_inc >= lvl_cnt_r || lvl_inc > jhd_pkg::LEVEL_MAX) ? 3'd0 : lvl_inc[2:0];

  // Take config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r      <= jhd_pkg::DEADZONE_RST;
      lvl_cnt_r <= jhd_pkg::LEVELS_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        jhd_pkg::REG_DEADZONE: dz_r      <= cfg_wdata;
        jhd_pkg::REG_LEVELS:   lvl_cnt_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Advance the speed level on a triangle release
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else if (cmd.load && evt.triangle_released) begin
      level_r <= lvl_nxt;
    end
  end

  // Latch the item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lx_r       <= evt.stick_lx;
      ly_r       <= evt.stick_ly;
      rx_r       <= evt.stick_rx;
      left_on_r  <= left_on;
      right_on_r <= right_on;
      plevel_r   <= evt.triangle_released ? level_r : 3'd0;
      pupd_r     <= evt.triangle_released;
    end
  end

  // Octant reduction of (x, -y)
  logic signed [8:0] px, py;
  logic [8:0]        ax9, ay9;
  logic [7:0]        ax, ay;
  logic [15:0]       sq_x, sq_y;
  logic [7:0]        oct_s, oct_l;
  logic [8:0]        oct_base;
  logic              oct_sub;

  assign px   = {lx_r[7], lx_r};
  assign py   = -$signed({ly_r[7], ly_r});
  assign ax9  = px[8] ? 9'(-px) : 9'(px);
  assign ay9  = py[8] ? 9'(-py) : 9'(py);
  assign ax   = ax9[7:0];
  assign ay   = ay9[7:0];
  assign sq_x = 16'(ax) * 16'(ax);
  assign sq_y = 16'(ay) * 16'(ay);

  always_comb begin
    oct_s    = ax;
    oct_l    = ay;
    oct_base = jhd_pkg::DEG_270;
    oct_sub  = 1'b0;
    if (px == 9'sd0 && py == 9'sd0) begin
      oct_s    = '0;
      oct_l    = '0;
      oct_base = jhd_pkg::DEG_0;
    end else if (px > 9'sd0 && py >= 9'sd0) begin
      if (ay <= ax) begin
        oct_s = ay; oct_l = ax; oct_base = jhd_pkg::DEG_0;
      end else begin
        oct_s = ax; oct_l = ay; oct_base = jhd_pkg::DEG_90; oct_sub = 1'b1;
      end
    end else if (px <= 9'sd0 && py > 9'sd0) begin
      if (ax <= ay) begin
        oct_s = ax; oct_l = ay; oct_base = jhd_pkg::DEG_90;
      end else begin
        oct_s = ay; oct_l = ax; oct_base = jhd_pkg::DEG_180; oct_sub = 1'b1;
      end
    end else if (px < 9'sd0 && py <= 9'sd0) begin
      if (ay <= ax) begin
        oct_s = ay; oct_l = ax; oct_base = jhd_pkg::DEG_180;
      end else begin
        oct_s = ax; oct_l = ay; oct_base = jhd_pkg::DEG_270; oct_sub = 1'b1;
      end
    end else begin
      if (ax <= ay) begin
        oct_s = ax; oct_l = ay; oct_base = jhd_pkg::DEG_270;
      end else begin
        oct_s = ay; oct_l = ax; oct_base = jhd_pkg::DEG_360; oct_sub = 1'b1;
      end
    end
  end

  // One step of the degree search: try the next bit of k
  logic [2:0]  srch_bit;
  logic [5:0]  cand;
  logic        cand_ok;
  logic [47:0] prod_s, prod_l;

  assign srch_bit = 3'(jhd_pkg::SEARCH_STEPS - 1) - cmd.step_idx;
  assign cand     = k_r | (6'd1 << srch_bit);
  assign prod_s   = {40'd0, s_r} * {8'd0, jhd_pkg::COS_TAB[cand]};
  assign prod_l   = {40'd0, l_r} * {8'd0, jhd_pkg::SIN_TAB[cand]};
  assign cand_ok  = cmd.step_idx < 3'(jhd_pkg::SEARCH_STEPS)
                    && cand <= 6'(jhd_pkg::OCT_STEPS) && prod_s >= prod_l;

  // One step of the square root: try the next root bit
  logic [2:0]  sq_bit;
  logic [7:0]  trial;
  logic [15:0] trial_sq;
  logic [15:0] radicand;

  assign sq_bit   = 3'(jhd_pkg::ITER_STEPS - 1) - cmd.step_idx;
  assign trial    = root_r | (8'd1 << sq_bit);
  assign trial_sq = 16'(trial) * 16'(trial);
  assign radicand = {sq_r[13:0], 2'b00};

  // Prepare and iterate
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      s_r    <= oct_s;
      l_r    <= oct_l;
      base_r <= oct_base;
      sub_r  <= oct_sub;
      sq_r   <= {1'b0, sq_x} + {1'b0, sq_y};
      k_r    <= '0;
      root_r <= '0;
    end else if (cmd.step) begin
      if (cand_ok) k_r <= cand;
      if (trial_sq <= radicand) root_r <= trial;
    end
  end

  // Assemble the result
  logic       exact_zero, exact_45, inexact, clamp;
  logic [5:0] k_eff;
  logic [8:0] angle, heading;
  logic [7:0] rx_mag;

  assign exact_zero = (s_r == 8'd0);
  assign exact_45   = !exact_zero && (s_r == l_r);
  assign inexact    = !exact_zero && !exact_45;
  assign k_eff      = exact_zero ? 6'd0 : (exact_45 ? jhd_pkg::DEG_45 : k_r);
  assign angle      = sub_r ? base_r - 9'(k_eff) - 9'(inexact) : base_r + 9'(k_eff);
  assign heading    = (angle > jhd_pkg::DEG_90) ? jhd_pkg::DEG_450 - angle
                                                : jhd_pkg::DEG_90 - angle;
  assign clamp      = |sq_r[16:14];
  assign rx_mag     = jhd_pkg::mag8(rx_r);

  always_comb begin
    res_nxt               = '0;
    res_nxt.player_level  = plevel_r;
    res_nxt.player_update = pupd_r;
    if (right_on_r) begin
      res_nxt.action     = jhd_pkg::ACT_ROTATE;
      res_nxt.magnitude  = {rx_mag, 1'b0};
      res_nxt.spin_right = !rx_r[7] && (rx_r != 8'sd0);
    end else if (left_on_r) begin
      res_nxt.action      = jhd_pkg::ACT_MOVE;
      res_nxt.heading_deg = heading;
      res_nxt.magnitude   = clamp ? jhd_pkg::MAG_FULL : {1'b0, root_r};
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) res_r <= res_nxt;
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign res           = res_r;

  `JHD_CHECK(a_no_overwrite, cmd.finish, !out_valid_r || out_ready, "result overwritten before taken")
  `JHD_CHECK_NEXT(a_finish_shows, cmd.finish, out_valid_r, "finished item not presented")
  `JHD_CHECK(a_heading_move_only, out_valid_r && res_r.action != jhd_pkg::ACT_MOVE, res_r.heading_deg == 9'd0, "heading set outside translate")

endmodule

>>> tb/joystick_to_heading_drive_unit_tb.sv
// Self-checking testbench of the joystick drive unit: random events, predicted commands
`timescale 1ns / 1ps

module joystick_to_heading_drive_unit_tb;
  import jhd_pkg::*;

  localparam int ITEMS_PER_PHASE = 170;
  localparam int PHASES          = 8;
  localparam int LONG_HOLD       = 300;
  localparam int SETTLE_CYCLES   = 12;

  // Predict the drive command of each accepted event and hold it until it comes out
  class drive_cmd_scoreboard;
    jhd_result_t expected_cmds[$];
    logic [7:0]  deadzone    = DEADZONE_RST;
    logic [3:0]  level_count = LEVELS_RST;
    logic [2:0]  speed_level = '0;
    int          mismatches  = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_DEADZONE) begin
        deadzone = data;
      end else begin
        level_count = data[3:0];
      end
    endfunction

    function int mag_of(int v);
      return (v < 0) ? -v : v;
    endfunction

    // Floor of the angle of (x, y) from the x axis in degrees, 0..359
    function int angle_floor(int x, int y);
      real d;
      if (x == 0 && y == 0) begin
        return 0;
      end
      d = $atan2(real'(y), real'(x)) * 180.0 / 3.14159265358979323846;
      if (d < 0.0) begin
        d = d + 360.0;
      end
      // axes and diagonals land on whole degrees; round them instead of flooring
      if (x == 0 || y == 0 || mag_of(x) == mag_of(y)) begin
        return int'(d) % 360;
      end
      return $rtoi($floor(d));
    endfunction

    function void note_event(jhd_event_t ev);
      jhd_result_t cmd;
      int x, y, a, sq, r, nxt;
      bit left_on, right_on;
      left_on  = mag_of($signed(ev.change_lx)) + mag_of($signed(ev.change_ly))
                 > int'(deadzone);
      right_on = mag_of($signed(ev.change_rx)) + mag_of($signed(ev.change_ry))
                 > int'(deadzone);
      cmd = '0;
      if (right_on) begin
        cmd.action     = ACT_ROTATE;
        cmd.magnitude  = 9'(2 * mag_of($signed(ev.stick_rx)));
        cmd.spin_right = ($signed(ev.stick_rx) > 0);
      end else if (left_on) begin
        x  = $signed(ev.stick_lx);
        y  = -$signed(ev.stick_ly);
        a  = angle_floor(x, y);
        cmd.action      = ACT_MOVE;
        cmd.heading_deg = 9'((a > 90) ? 450 - a : 90 - a);
        // integer square root of 4*(x^2+y^2), clamped to full scale
        sq = 4 * (x * x + y * y);
        r  = $rtoi($sqrt(real'(sq)));
        while (r * r > sq) r--;
        while ((r + 1) * (r + 1) <= sq) r++;
        cmd.magnitude = (r > int'(MAG_FULL)) ? MAG_FULL : 9'(r);
      end
      // report the level, then advance it with wrap
      if (ev.triangle_released) begin
        cmd.player_level  = speed_level;
        cmd.player_update = 1'b1;
        nxt = int'(speed_level) + 1;
        if (nxt >= int'(level_count) || nxt > int'(LEVEL_MAX)) begin
          nxt = 0;
        end
        speed_level = 3'(nxt);
      end
      expected_cmds.push_back(cmd);
    endfunction

    function void field_check(string name, int want, int seen);
      if (want != seen) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, seen);
        mismatches++;
      end
    endfunction

    function void check_result(jhd_result_t got);
      jhd_result_t want;
      if (expected_cmds.size() == 0) begin
        $display("%0t: command with none expected, expected nothing actual %h",
                 $time, got);
        mismatches++;
        return;
      end
      want = expected_cmds.pop_front();
      field_check("action", want.action, got.action);
      field_check("heading_deg", want.heading_deg, got.heading_deg);
      field_check("magnitude", want.magnitude, got.magnitude);
      field_check("spin_right", want.spin_right, got.spin_right);
      field_check("player_level", want.player_level, got.player_level);
      field_check("player_update", want.player_update, got.player_update);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  jhd_in_if  in_ch ();
  jhd_out_if out_ch ();

  drive_cmd_scoreboard sb;
  bit src_gaps_on;
  bit sink_gaps_on;
  int hold_requests;

  joystick_to_heading_drive_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Bound the run in case the block hangs
  initial begin
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Full range, values near zero, or corners
  function automatic logic signed [7:0] rand_byte();
    int pick;
    int v;
    logic signed [7:0] corner [6];
    corner = '{-8'sd128, -8'sd127, -8'sd1, 8'sd0, 8'sd1, 8'sd127};
    pick = $urandom_range(0, 99);
    if (pick < 45) return 8'($urandom);
    if (pick < 80) begin
      v = $urandom_range(0, 5);
      return $urandom_range(0, 1) ? 8'(-v) : 8'(v);
    end
    return corner[$urandom_range(0, 5)];
  endfunction

  function automatic jhd_event_t random_event();
    jhd_event_t ev;
    ev.change_lx = rand_byte();
    ev.change_ly = rand_byte();
    ev.change_rx = rand_byte();
    ev.change_ry = rand_byte();
    ev.stick_lx  = rand_byte();
    ev.stick_ly  = rand_byte();
    ev.stick_rx  = rand_byte();
    ev.triangle_released = ($urandom_range(0, 3) == 0);
    // sometimes put the left stick on a diagonal
    if ($urandom_range(0, 6) == 0) begin
      ev.stick_ly = $urandom_range(0, 1) ? ev.stick_lx : 8'(-ev.stick_lx);
    end
    return ev;
  endfunction

  function automatic jhd_event_t pack_event(int dlx, int dly, int drx, int dry,
                                            int lx, int ly, int rx, bit tri_rel);
    jhd_event_t ev;
    ev.change_lx = 8'(dlx);
    ev.change_ly = 8'(dly);
    ev.change_rx = 8'(drx);
    ev.change_ry = 8'(dry);
    ev.stick_lx  = 8'(lx);
    ev.stick_ly  = 8'(ly);
    ev.stick_rx  = 8'(rx);
    ev.triangle_released = tri_rel;
    return ev;
  endfunction

  // Offer one item after an optional gap; note it once accepted
  task automatic send_event(input jhd_event_t ev);
    int gap;
    gap = src_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid             = 1'b1;
    in_ch.change_lx         = ev.change_lx;
    in_ch.change_ly         = ev.change_ly;
    in_ch.change_rx         = ev.change_rx;
    in_ch.change_ry         = ev.change_ry;
    in_ch.stick_lx          = ev.stick_lx;
    in_ch.stick_ly          = ev.stick_ly;
    in_ch.stick_rx          = ev.stick_rx;
    in_ch.triangle_released = ev.triangle_released;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_event(ev);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Hold until every command is out and the pipeline has settled
  task automatic wait_idle();
    while (sb.expected_cmds.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Result side: random stalls plus the long hold on request
  initial begin : sink_side
    int stall_left;
    int holds_done;
    int gap;
    stall_left   = 0;
    holds_done   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        gap = sink_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
          out_ch.ready = 1'b0;
          stall_left   = gap - 1;
        end else begin
          out_ch.ready = 1'b1;
        end
      end
    end
  end

  // Check each command as it is accepted
  always @(posedge clk) begin : take_result
    jhd_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.action        = out_ch.action;
      got.heading_deg   = out_ch.heading_deg;
      got.magnitude     = out_ch.magnitude;
      got.spin_right    = out_ch.spin_right;
      got.player_level  = out_ch.player_level;
      got.player_update = out_ch.player_update;
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    jhd_event_t directed_evs[$];
    int dz;
    int cnt;
    int n;
    sb            = new;
    src_gaps_on   = 1'b1;
    sink_gaps_on  = 1'b1;
    hold_requests = 0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = REG_DEADZONE;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.change_lx = '0;
    in_ch.change_ly = '0;
    in_ch.change_rx = '0;
    in_ch.change_ry = '0;
    in_ch.stick_lx  = '0;
    in_ch.stick_ly  = '0;
    in_ch.stick_rx  = '0;
    in_ch.triangle_released = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed items under the reset settings
    directed_evs.push_back(pack_event(0, 0, 0, 0, 0, 0, 0, 0));
    // summed change equal to the deadzone stays idle
    directed_evs.push_back(pack_event(2, 0, 0, 0, 127, 0, 0, 0));
    directed_evs.push_back(pack_event(2, 1, 0, 0, 127, 0, 0, 0));
    // far corner: magnitude clamps to full scale
    directed_evs.push_back(pack_event(-128, -128, 0, 0, -128, -128, 0, 0));
    directed_evs.push_back(pack_event(3, 0, 0, 0, 0, -128, 0, 0));
    directed_evs.push_back(pack_event(0, 3, 0, 0, 0, 127, 0, 0));
    directed_evs.push_back(pack_event(0, -3, 0, 0, -128, 0, 0, 0));
    // stick at center while moving
    directed_evs.push_back(pack_event(1, -2, 0, 0, 0, 0, 0, 0));
    directed_evs.push_back(pack_event(5, 5, 0, 0, 127, -127, 0, 0));
    directed_evs.push_back(pack_event(5, 5, 0, 0, 127, 127, 0, 0));
    directed_evs.push_back(pack_event(5, 5, 0, 0, -100, 37, 0, 0));
    directed_evs.push_back(pack_event(5, 5, 0, 0, 1, -128, 0, 0));
    directed_evs.push_back(pack_event(0, 0, 2, 1, 0, 0, 127, 0));
    directed_evs.push_back(pack_event(0, 0, -128, -128, 0, 0, -128, 0));
    // rotate with the right stick centered
    directed_evs.push_back(pack_event(0, 0, 0, 3, 0, 0, 0, 0));
    directed_evs.push_back(pack_event(0, 0, 2, 0, 0, 0, 5, 0));
    // both sticks active: rotate wins
    directed_evs.push_back(pack_event(9, 9, 9, 9, 50, 50, -1, 1));
    // triangle releases with no stick: walk the level through its wrap
    repeat (5) directed_evs.push_back(pack_event(0, 0, 0, 0, 0, 0, 0, 1));
    directed_evs.push_back(pack_event(127, 127, 127, 127, 127, 127, 127, 1));
    directed_evs.push_back(pack_event(3, 0, 0, 0, -128, 127, 0, 1));
    foreach (directed_evs[i]) send_event(directed_evs[i]);

    // Random phases, each under its own settings
    for (int phase = 0; phase < PHASES; phase++) begin
      src_gaps_on  = 1'b1;
      sink_gaps_on = 1'b1;
      case (phase)
        0: begin dz = DEADZONE_RST; cnt = LEVELS_RST; end
        1: begin dz = 0; cnt = 8; end
        2: begin
          dz = 255; cnt = 1;
          src_gaps_on  = 1'b0;
          sink_gaps_on = 1'b0;
        end
        3: begin dz = 4; cnt = 3; end
        5: begin dz = 1; cnt = 7; src_gaps_on = 1'b0; end
        7: begin dz = 3; cnt = 8; end
        default: begin
          dz  = $urandom_range(0, 20);
          cnt = $urandom_range(1, 8);
        end
      endcase
      wait_idle();
      write_reg(REG_DEADZONE, CFG_DATA_W'(dz));
      write_reg(REG_LEVELS, CFG_DATA_W'(cnt));
      // long result-side hold while events keep coming
      if (phase == 3) begin
        hold_requests++;
      end
      repeat (ITEMS_PER_PHASE) send_event(random_event());
    end
    in_ch.valid = 1'b0;

    // Drain with a limit, then let the pipeline settle
    n = 0;
    while (sb.expected_cmds.size() != 0 && n < 20000) begin
      @(negedge clk);
      n++;
    end
    repeat (2 * SETTLE_CYCLES) @(negedge clk);
    if (sb.expected_cmds.size() != 0) begin
      $display("%0t: %0d commands never arrived", $time, sb.expected_cmds.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
